// File: src/vfdc_pkg.sv
// Package for the video frame descriptor checker: field widths, command and
// status codes, and the layout of one request and one result.
// No dependencies.
package vfdc_pkg;

    localparam int DIM_W   = 16;
    localparam int FMT_W   = 4;
    localparam int LEN_W   = 32;
    localparam int TIME_W  = 48;
    localparam int ID_W    = 32;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    // Dimensions that pass the checks are positive, so 15 magnitude bits do.
    localparam int MAG_W   = DIM_W - 1;
    localparam int PROD_W  = 2 * MAG_W;

    localparam int IN_FIELDS_W  = 2 * DIM_W + FMT_W + LEN_W + TIME_W + ID_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + 1 + 3 * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_CLOSED   = 3'd1,
        ST_NONPOS   = 3'd2,
        ST_ODD      = 3'd3,
        ST_FORMAT   = 3'd4,
        ST_LENGTH   = 3'd5,
        ST_TIME     = 3'd6,
        ST_ID       = 3'd7
    } t_status;

    // Packed lowest field last so that the struct matches tdata bit for bit.
    typedef struct packed {
        logic [ID_W-1:0]          frame_number;
        logic [TIME_W-1:0]        capture_time_ms;
        logic [LEN_W-1:0]         payload_bytes;
        logic [FMT_W-1:0]         format_code;
        logic signed [DIM_W-1:0]  frame_height;
        logic signed [DIM_W-1:0]  frame_width;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]  rebuild_count;
        logic [CNT_W-1:0]  rejected_count;
        logic [CNT_W-1:0]  accepted_count;
        logic              rebuild_needed;
        t_status           status;
    } t_out_item;

endpackage

// File: src/video_frame_descriptor_checker.sv
// Video frame descriptor checker top level: input register, check logic,
// history and counters, result register. Depends on vfdc_pkg.
//
//  channel  | direction | signals                         | accepted when
//  ---------+-----------+---------------------------------+--------------------
//  s_axis   | in        | tvalid tready tdata tuser       | tvalid && tready
//  m_axis   | out       | tvalid tready tdata             | tvalid && tready
//  cfg      | in        | i_cfg_valid o_cfg_ready data    | valid && ready
//
// One request per cycle sustained while the sink keeps m_axis_tready high; a
// request passes the input register (which takes the size product), then the
// result register, where the history and counters update.
// The result register is a one-entry stage: a new request is taken while a
// result waits, and the input stalls only when both stages are full.
// i_rst_n is synchronous: it clears both stages, the session, the history,
// the counters and the format register.
module video_frame_descriptor_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, from bit 0: frame_width, frame_height, format_code,
    // payload_bytes, capture_time_ms, frame_number, zero fill
    input  logic [vfdc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: command
    input  logic [vfdc_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, from bit 0: status, rebuild_needed, accepted_count,
    // rejected_count, rebuild_count, zero fill
    output logic [vfdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vfdc_pkg::FMT_W-1:0]        i_cfg_data
);

    localparam int PW = vfdc_pkg::PROD_W;

    // Input stage
    logic                       r_in_valid;
    vfdc_pkg::t_in_item         r_in;
    logic [vfdc_pkg::CMD_W-1:0] r_in_cmd;
    logic [PW-1:0]              r_prod;
    vfdc_pkg::t_in_item         s_item;

    // Output stage
    logic                       r_out_valid;
    vfdc_pkg::t_out_item        r_out;
    vfdc_pkg::t_out_item        n_out;

    // Session state
    logic [vfdc_pkg::FMT_W-1:0] r_accepted_fmt;
    logic                       r_is_open, n_is_open;
    logic                       r_have_prev, n_have_prev;
    logic [vfdc_pkg::DIM_W-1:0] r_last_w, n_last_w;
    logic [vfdc_pkg::DIM_W-1:0] r_last_h, n_last_h;
    logic [vfdc_pkg::TIME_W-1:0] r_last_t, n_last_t;
    logic [vfdc_pkg::ID_W-1:0]  r_last_id, n_last_id;
    logic [vfdc_pkg::CNT_W-1:0] r_acc_cnt, n_acc_cnt;
    logic [vfdc_pkg::CNT_W-1:0] r_rej_cnt, n_rej_cnt;
    logic [vfdc_pkg::CNT_W-1:0] r_reb_cnt, n_reb_cnt;

    logic                       advance;
    logic [PW:0]                expect_len;
    vfdc_pkg::t_status          chk_status;

    assign s_item        = vfdc_pkg::t_in_item'(s_axis_tdata[vfdc_pkg::IN_FIELDS_W-1:0]);
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = vfdc_pkg::OUT_TDATA_W'(r_out);

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_fmt <= '0;
        end else if (i_cfg_valid) begin
            r_accepted_fmt <= i_cfg_data;
        end
    end

    // Input register; the width*height product is taken on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in     <= s_item;
            r_in_cmd <= s_axis_tuser;
            r_prod   <= PW'(s_item.frame_width[vfdc_pkg::MAG_W-1:0])
                        * PW'(s_item.frame_height[vfdc_pkg::MAG_W-1:0]);
        end
    end

    // w*h*3/2; the product is even whenever the length test is reached
    assign expect_len = {1'b0, r_prod} + {2'b00, r_prod[PW-1:1]};

    always_comb begin
        chk_status = vfdc_pkg::ST_OK;
        if (r_in.frame_width[vfdc_pkg::DIM_W-1] || r_in.frame_width == '0
            || r_in.frame_height[vfdc_pkg::DIM_W-1] || r_in.frame_height == '0) begin
            chk_status = vfdc_pkg::ST_NONPOS;
        end else if (r_in.frame_width[0] || r_in.frame_height[0]) begin
            chk_status = vfdc_pkg::ST_ODD;
        end else if (r_in.format_code != r_accepted_fmt) begin
            chk_status = vfdc_pkg::ST_FORMAT;
        end else if (r_in.payload_bytes != vfdc_pkg::LEN_W'(expect_len)) begin
            chk_status = vfdc_pkg::ST_LENGTH;
        end else if (r_have_prev && r_in.capture_time_ms != '0 && r_last_t != '0
                     && r_in.capture_time_ms <= r_last_t) begin
            chk_status = vfdc_pkg::ST_TIME;
        end else if (r_have_prev && r_in.frame_number != '0 && r_last_id != '0
                     && r_in.frame_number <= r_last_id) begin
            chk_status = vfdc_pkg::ST_ID;
        end
    end

    // Next session state and result
    always_comb begin
        n_is_open   = r_is_open;
        n_have_prev = r_have_prev;
        n_last_w    = r_last_w;
        n_last_h    = r_last_h;
        n_last_t    = r_last_t;
        n_last_id   = r_last_id;
        n_acc_cnt   = r_acc_cnt;
        n_rej_cnt   = r_rej_cnt;
        n_reb_cnt   = r_reb_cnt;
        n_out.status         = vfdc_pkg::ST_OK;
        n_out.rebuild_needed = 1'b0;
        case (r_in_cmd)
            vfdc_pkg::CMD_OPEN: begin
                n_is_open   = 1'b1;
                n_have_prev = 1'b0;
                n_last_w    = '0;
                n_last_h    = '0;
                n_last_t    = '0;
                n_last_id   = '0;
                n_acc_cnt   = '0;
                n_rej_cnt   = '0;
                n_reb_cnt   = '0;
            end
            vfdc_pkg::CMD_CLOSE: begin
                n_is_open   = 1'b0;
                n_have_prev = 1'b0;
                n_last_w    = '0;
                n_last_h    = '0;
                n_last_t    = '0;
                n_last_id   = '0;
            end
            vfdc_pkg::CMD_FRAME: begin
                if (!r_is_open) begin
                    n_out.status = vfdc_pkg::ST_CLOSED;
                end else if (chk_status != vfdc_pkg::ST_OK) begin
                    n_out.status = chk_status;
                    n_rej_cnt    = r_rej_cnt + 1'b1;
                end else begin
                    if (!r_have_prev || r_in.frame_width != r_last_w
                        || r_in.frame_height != r_last_h) begin
                        n_out.rebuild_needed = 1'b1;
                        n_reb_cnt            = r_reb_cnt + 1'b1;
                    end
                    n_have_prev = 1'b1;
                    n_last_w    = r_in.frame_width;
                    n_last_h    = r_in.frame_height;
                    // zero is a sentinel: keep the baseline
                    if (r_in.capture_time_ms != '0) n_last_t  = r_in.capture_time_ms;
                    if (r_in.frame_number != '0)    n_last_id = r_in.frame_number;
                    n_acc_cnt = r_acc_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_out.accepted_count = n_acc_cnt;
        n_out.rejected_count = n_rej_cnt;
        n_out.rebuild_count  = n_reb_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_open   <= 1'b0;
            r_have_prev <= 1'b0;
            r_last_w    <= '0;
            r_last_h    <= '0;
            r_last_t    <= '0;
            r_last_id   <= '0;
            r_acc_cnt   <= '0;
            r_rej_cnt   <= '0;
            r_reb_cnt   <= '0;
        end else if (advance) begin
            r_is_open   <= n_is_open;
            r_have_prev <= n_have_prev;
            r_last_w    <= n_last_w;
            r_last_h    <= n_last_h;
            r_last_t    <= n_last_t;
            r_last_id   <= n_last_id;
            r_acc_cnt   <= n_acc_cnt;
            r_rej_cnt   <= n_rej_cnt;
            r_reb_cnt   <= n_reb_cnt;
        end
    end

    // Result register: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: src/vfdc_checker.sv
// Port-level checks for the video frame descriptor checker, bound to the
// top level. Depends on vfdc_pkg and video_frame_descriptor_checker.
module vfdc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [vfdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    vfdc_pkg::t_out_item out_item;
    assign out_item = vfdc_pkg::t_out_item'(m_axis_tdata[vfdc_pkg::OUT_FIELDS_W-1:0]);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Every taken request shows a result after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("no result two cycles after a request");

    // A rebuild only comes with an accepted frame
    a_rebuild_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_item.rebuild_needed |-> out_item.status == vfdc_pkg::ST_OK)
        else $error("rebuild flagged on a rejected frame");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind video_frame_descriptor_checker vfdc_checker u_vfdc_checker (.*);

// File: test/video_frame_descriptor_checker_tb.sv
// Testbench for video_frame_descriptor_checker: directed descriptor checks, format
// register settings and random frame streams with stalls, all against a local predictor.
// Depends on vfdc_pkg and the checker RTL.
module video_frame_descriptor_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [vfdc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [vfdc_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [vfdc_pkg::CMD_W-1:0]        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [vfdc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [vfdc_pkg::FMT_W-1:0]        i_cfg_data = '0;

    // Predictor state
    logic [vfdc_pkg::FMT_W-1:0]   fmt_sel = '0;
    logic                         sess_open = 1'b0;
    logic                         have_prev = 1'b0;
    logic [vfdc_pkg::DIM_W-1:0]   prev_w = '0;
    logic [vfdc_pkg::DIM_W-1:0]   prev_h = '0;
    logic [vfdc_pkg::TIME_W-1:0]  prev_time = '0;
    logic [vfdc_pkg::ID_W-1:0]    prev_id = '0;
    logic [vfdc_pkg::CNT_W-1:0]   acc_total = '0;
    logic [vfdc_pkg::CNT_W-1:0]   rej_total = '0;
    logic [vfdc_pkg::CNT_W-1:0]   rbld_total = '0;

    vfdc_pkg::t_out_item expected_verdicts[$];

    bit no_gaps = 1'b0;
    int err_count = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_frames_ok = 0;
    int n_frames_bad = 0;
    int n_rebuilds = 0;
    int n_formats = 0;

    video_frame_descriptor_checker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 14);
    end

    function automatic logic [vfdc_pkg::LEN_W-1:0] yuv420_bytes(
            input logic [vfdc_pkg::DIM_W-1:0] w,
            input logic [vfdc_pkg::DIM_W-1:0] h);
        logic [63:0] area;
        area = {48'd0, w} * {48'd0, h};
        return vfdc_pkg::LEN_W'(area + (area >> 1));
    endfunction

    function automatic vfdc_pkg::t_in_item make_frame(
            input logic [vfdc_pkg::DIM_W-1:0] w,
            input logic [vfdc_pkg::DIM_W-1:0] h,
            input logic [vfdc_pkg::FMT_W-1:0] fmt,
            input logic [vfdc_pkg::LEN_W-1:0] len,
            input logic [vfdc_pkg::TIME_W-1:0] t,
            input logic [vfdc_pkg::ID_W-1:0] id);
        vfdc_pkg::t_in_item d;
        d.frame_width     = w;
        d.frame_height    = h;
        d.format_code     = fmt;
        d.payload_bytes   = len;
        d.capture_time_ms = t;
        d.frame_number    = id;
        return d;
    endfunction

    function automatic vfdc_pkg::t_out_item predict_descriptor(
            input logic [vfdc_pkg::CMD_W-1:0] cmd,
            input vfdc_pkg::t_in_item d);
        vfdc_pkg::t_out_item res;
        logic [63:0] area;
        res = '0;
        res.status = vfdc_pkg::ST_OK;
        case (cmd)
            vfdc_pkg::CMD_OPEN: begin
                sess_open  = 1'b1;
                have_prev  = 1'b0;
                prev_w     = '0;
                prev_h     = '0;
                prev_time  = '0;
                prev_id    = '0;
                acc_total  = '0;
                rej_total  = '0;
                rbld_total = '0;
            end
            vfdc_pkg::CMD_CLOSE: begin
                sess_open = 1'b0;
                have_prev = 1'b0;
                prev_w    = '0;
                prev_h    = '0;
                prev_time = '0;
                prev_id   = '0;
            end
            vfdc_pkg::CMD_FRAME: begin
                area = {48'd0, d.frame_width} * {48'd0, d.frame_height};
                if (!sess_open)
                    res.status = vfdc_pkg::ST_CLOSED;
                else if ($signed(d.frame_width) <= 0 || $signed(d.frame_height) <= 0)
                    res.status = vfdc_pkg::ST_NONPOS;
                else if (d.frame_width[0] || d.frame_height[0])
                    res.status = vfdc_pkg::ST_ODD;
                else if (d.format_code != fmt_sel)
                    res.status = vfdc_pkg::ST_FORMAT;
                else if ({32'd0, d.payload_bytes} != area + (area >> 1))
                    res.status = vfdc_pkg::ST_LENGTH;
                // zero on either side of an ordering test skips it
                else if (have_prev && d.capture_time_ms != 0 && prev_time != 0
                         && d.capture_time_ms <= prev_time)
                    res.status = vfdc_pkg::ST_TIME;
                else if (have_prev && d.frame_number != 0 && prev_id != 0
                         && d.frame_number <= prev_id)
                    res.status = vfdc_pkg::ST_ID;

                if (sess_open && res.status != vfdc_pkg::ST_OK) begin
                    rej_total = rej_total + 1'b1;
                end else if (sess_open) begin
                    if (!have_prev || d.frame_width != prev_w
                        || d.frame_height != prev_h) begin
                        res.rebuild_needed = 1'b1;
                        rbld_total = rbld_total + 1'b1;
                    end
                    have_prev = 1'b1;
                    prev_w    = d.frame_width;
                    prev_h    = d.frame_height;
                    if (d.capture_time_ms != 0) prev_time = d.capture_time_ms;
                    if (d.frame_number != 0) prev_id = d.frame_number;
                    acc_total = acc_total + 1'b1;
                end
            end
            default: ;
        endcase
        res.accepted_count = acc_total;
        res.rejected_count = rej_total;
        res.rebuild_count  = rbld_total;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Drive one request and hold it until taken; predict on acceptance.
    task automatic send_request(input logic [vfdc_pkg::CMD_W-1:0] cmd,
                                input vfdc_pkg::t_in_item d);
        vfdc_pkg::t_out_item res;
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = vfdc_pkg::IN_TDATA_W'(d);
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        res = predict_descriptor(cmd, d);
        expected_verdicts.push_back(res);
        n_requests++;
        if (cmd == vfdc_pkg::CMD_FRAME && res.status == vfdc_pkg::ST_OK) n_frames_ok++;
        if (res.status > vfdc_pkg::ST_CLOSED) n_frames_bad++;
        if (res.rebuild_needed) n_rebuilds++;
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_format(input logic [vfdc_pkg::FMT_W-1:0] fmt);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = fmt;
        do @(posedge i_clk); while (!o_cfg_ready);
        fmt_sel = fmt;
        n_formats++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        vfdc_pkg::t_out_item got;
        vfdc_pkg::t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[vfdc_pkg::OUT_FIELDS_W-1:0];
            n_results++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with no request pending", got.status, 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.rebuild_needed != want.rebuild_needed)
                    report_mismatch("rebuild_needed", got.rebuild_needed, want.rebuild_needed);
                if (got.accepted_count != want.accepted_count)
                    report_mismatch("accepted_count", got.accepted_count, want.accepted_count);
                if (got.rejected_count != want.rejected_count)
                    report_mismatch("rejected_count", got.rejected_count, want.rejected_count);
                if (got.rebuild_count != want.rebuild_count)
                    report_mismatch("rebuild_count", got.rebuild_count, want.rebuild_count);
            end
        end
    end

    // Each rejection reason in check order, sentinels, extreme sizes, close and reopen.
    task automatic test_directed_checks();
        logic [vfdc_pkg::LEN_W-1:0] big_len;
        big_len = yuv420_bytes(16'd32766, 16'd32766);
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd1, 32'd1));
        send_request(CMD_UNUSED, '0);
        send_request(vfdc_pkg::CMD_OPEN, '0);
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd0, 16'd2, 4'd0, 32'd0, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'h8000, 16'd2, 4'd0, 32'd6, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'hFFFE, 4'd0, 32'd6, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd3, 16'd2, 4'd5, 32'd9, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'h7FFF, 4'd0, 32'd6, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd2, 16'd2, 4'd9, 32'd0, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'hFFFF_FFFF, 48'd1, 32'd1));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd100, 32'd5));
        // equal time and older id: time wins
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd100, 32'd4));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd101, 32'd5));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd0, 32'd0));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd0, 32'd6));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd102, 32'd0));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd32766, 16'd32766, 4'd0, big_len,
                                                     48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd32766, 16'd32766, 4'd0, big_len, 48'd1, 32'd0));
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd32766, 16'd32766, 4'd0, big_len, 48'd0, 32'd1));
        send_request(vfdc_pkg::CMD_CLOSE, '0);
        send_request(vfdc_pkg::CMD_FRAME,
                     make_frame(16'd2, 16'd2, 4'd0, 32'd6, 48'd500, 32'd50));
        send_request(CMD_UNUSED, '1);
        send_request(vfdc_pkg::CMD_OPEN, '1);
        // zero baselines after open let any later value through
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd32766, 16'd2, 4'd0,
                                           yuv420_bytes(16'd32766, 16'd2), 48'd0, 32'd0));
        send_request(vfdc_pkg::CMD_FRAME, make_frame(16'd2, 16'd32766, 4'd0,
                                           yuv420_bytes(16'd2, 16'd32766), 48'd7, 32'd3));
        drain_pipeline();
    endtask

    task automatic test_format_register();
        logic [vfdc_pkg::FMT_W-1:0] fmt;
        for (int n = 0; n < 3; n++) begin
            fmt = (n == 0) ? 4'hF : (n == 1) ? 4'h0
                                             : vfdc_pkg::FMT_W'($urandom_range(1, 14));
            drain_pipeline();
            write_format(fmt);
            send_request(vfdc_pkg::CMD_OPEN, '0);
            send_request(vfdc_pkg::CMD_FRAME,
                         make_frame(16'd4, 16'd2, fmt, 32'd12, 48'd10, 32'd1));
            send_request(vfdc_pkg::CMD_FRAME,
                         make_frame(16'd4, 16'd2, ~fmt, 32'd12, 48'd11, 32'd2));
            send_request(vfdc_pkg::CMD_FRAME,
                         make_frame(16'd4, 16'd2, fmt, 32'd12, 48'd11, 32'd2));
        end
        drain_pipeline();
    endtask

    // Mostly well-formed frame streams with rising time and id, some corrupted,
    // plus the odd open, close and unused command.
    task automatic test_random_traffic();
        vfdc_pkg::t_in_item d;
        logic [vfdc_pkg::CMD_W-1:0] cmd;
        logic [159:0] noise;
        logic [vfdc_pkg::DIM_W-1:0] gw;
        logic [vfdc_pkg::DIM_W-1:0] gh;
        logic [vfdc_pkg::TIME_W-1:0] clk_ms;
        logic [vfdc_pkg::ID_W-1:0] id_seq;
        int pick;
        clk_ms = 48'd1000;
        id_seq = 32'd10;
        gw = 16'd64;
        gh = 16'd48;
        for (int ph = 0; ph < 4; ph++) begin
            drain_pipeline();
            no_gaps = (ph == 2);
            write_format(vfdc_pkg::FMT_W'($urandom_range(0, 15)));
            send_request(vfdc_pkg::CMD_OPEN, '0);
            for (int k = 0; k < 150; k++) begin
                noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
                d = noise[vfdc_pkg::IN_FIELDS_W-1:0];
                pick = $urandom_range(0, 99);
                if (!sess_open && pick < 60) begin
                    cmd = vfdc_pkg::CMD_OPEN;
                end else if (pick < 2) begin
                    cmd = vfdc_pkg::CMD_OPEN;
                end else if (pick < 4) begin
                    cmd = vfdc_pkg::CMD_CLOSE;
                end else if (pick < 5) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = vfdc_pkg::CMD_FRAME;
                    if ($urandom_range(0, 99) < 8) begin
                        gw = ($urandom_range(0, 19) == 0)
                             ? vfdc_pkg::DIM_W'(2 * $urandom_range(1, 16383))
                             : vfdc_pkg::DIM_W'(2 * $urandom_range(1, 64));
                        gh = ($urandom_range(0, 19) == 0)
                             ? vfdc_pkg::DIM_W'(2 * $urandom_range(1, 16383))
                             : vfdc_pkg::DIM_W'(2 * $urandom_range(1, 64));
                    end
                    clk_ms = clk_ms + $urandom_range(1, 40);
                    id_seq = id_seq + $urandom_range(1, 3);
                    d = make_frame(gw, gh, fmt_sel, yuv420_bytes(gw, gh),
                                   ($urandom_range(0, 19) == 0) ? '0 : clk_ms,
                                   ($urandom_range(0, 19) == 0) ? '0 : id_seq);
                    if (pick >= 80) begin
                        case ($urandom_range(0, 6))
                            0: d.frame_width = noise[15:0];
                            1: d.frame_height = noise[31:16];
                            2: d.format_code = noise[35:32];
                            3: d.payload_bytes = noise[67:36];
                            4: d.payload_bytes = d.payload_bytes
                                                 ^ vfdc_pkg::LEN_W'(1 << $urandom_range(0, 31));
                            5: d.capture_time_ms = clk_ms - $urandom_range(0, 60);
                            default: d.frame_number = id_seq - $urandom_range(0, 4);
                        endcase
                    end
                end
                send_request(cmd, d);
            end
        end
        drain_pipeline();
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_checks();
        test_format_register();
        test_random_traffic();
        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (expected_verdicts.size() != 0)
            report_mismatch("requests left without a result", expected_verdicts.size(), 0);
        $display("Run covered %0d requests and %0d results over %0d format settings:",
                 n_requests, n_results, n_formats);
        $display("  %0d frames accepted, %0d rejected by checks, %0d rebuilds, %0d mismatches",
                 n_frames_ok, n_frames_bad, n_rebuilds, err_count);
        if (err_count == 0) begin
            $display("PASS video_frame_descriptor_checker");
        end else begin
            $display("FAIL video_frame_descriptor_checker");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL video_frame_descriptor_checker");
        $finish;
    end

endmodule
